// ----- rtl/core/jfhs_pkg.sv -----
// Types and constants shared by the JPEG frame header scanner modules.
// Depends on nothing; every other file imports it.
package jfhs_pkg;

   // Result status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_JPEG   = 3'd1;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
   localparam logic [2:0] ST_SHORT_SOF  = 3'd3;
   localparam logic [2:0] ST_BAD_VALUES = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

   // Marker bytes.
   localparam logic [7:0] MK_PREFIX    = 8'hFF;
   localparam logic [7:0] MK_SOI       = 8'hD8;
   localparam logic [7:0] MK_EOI       = 8'hD9;
   localparam logic [7:0] MK_SOS       = 8'hDA;
   localparam logic [7:0] MK_RST_FIRST = 8'hD0;
   localparam logic [7:0] MK_RST_LAST  = 8'hD7;
   localparam logic [7:0] MK_SOF_FIRST = 8'hC0;
   localparam logic [7:0] MK_SOF_LAST  = 8'hCF;
   localparam logic [7:0] MK_DHT       = 8'hC4;
   localparam logic [7:0] MK_JPG       = 8'hC8;
   localparam logic [7:0] MK_DAC       = 8'hCC;

   // Number of SOF body bytes kept: precision, height, width, components.
   localparam logic [2:0] SOF_HDR_BYTES = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [7:0]  component_count;
      logic [7:0]  sample_precision;
   } rsp_type;

   // Handshake between the input register and the parser.
   typedef struct packed {
      logic item_valid;
      logic consume;
   } stage_ctl_type;

endpackage

// ----- rtl/core/jfhs_in_reg.sv -----
// Input register of the JPEG frame header scanner.
// Holds one byte item until the parser consumes it. Uses jfhs_pkg.
module jfhs_in_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  jfhs_pkg::req_type       req_item,
   input  logic                    consume,
   output jfhs_pkg::stage_ctl_type ctl,
   output jfhs_pkg::req_type       item
);
   import jfhs_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    take;

   assign req_stall = valid_ff && !consume;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign ctl.item_valid = valid_ff;
   assign ctl.consume    = consume;
   assign item           = item_ff;

endmodule

// ----- rtl/core/jfhs_parser.sv -----
// Marker scanner and SOF capture of the JPEG frame header scanner.
// Updates the parse state once per consumed byte and flags a result. Uses jfhs_pkg.
module jfhs_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  jfhs_pkg::stage_ctl_type ctl,
   input  jfhs_pkg::req_type       item,
   output logic                    has_result,
   output jfhs_pkg::rsp_type       result
);
   import jfhs_pkg::*;

   typedef enum logic [2:0] {
      PH_START0,
      PH_START1,
      PH_SEEK,
      PH_FILL,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_BODY,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] remain_ff, remain_in;
   logic [2:0]  index_ff, index_in;
   logic        is_sof_ff, is_sof_in;
   logic [2:0]  seen_ff, seen_in;
   logic [47:0] header_ff, header_in;
   logic [15:0] seg_len;
   logic [7:0]  b;

   function automatic logic sof_marker(input logic [7:0] m);
      return (m >= MK_SOF_FIRST) && (m <= MK_SOF_LAST) &&
             (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
   endfunction

   function automatic rsp_type error_rsp(input logic [2:0] code);
      rsp_type r;
      r        = '0;
      r.status = code;
      return r;
   endfunction

   // Judge a complete SOF segment from the captured body bytes.
   function automatic rsp_type finish_sof(input logic [2:0] idx, input logic [47:0] hdr);
      rsp_type    r;
      logic [7:0] comps;
      r     = '0;
      comps = hdr[7:0];
      if (idx < SOF_HDR_BYTES) begin
         r.status = ST_SHORT_SOF;
      end else if (hdr[23:8] == 16'd0 || hdr[39:24] == 16'd0 ||
                   (comps != 8'd1 && comps != 8'd3 && comps != 8'd4)) begin
         r.status = ST_BAD_VALUES;
      end else begin
         r.status           = ST_OK;
         r.component_count  = comps;
         r.image_width      = hdr[23:8];
         r.image_height     = hdr[39:24];
         r.sample_precision = hdr[47:40];
      end
      return r;
   endfunction

   assign b       = item.data_byte;
   assign seg_len = {remain_ff[15:8], b};

   always_comb begin
      phase_in   = phase_ff;
      remain_in  = remain_ff;
      index_in   = index_ff;
      is_sof_in  = is_sof_ff;
      seen_in    = seen_ff;
      header_in  = header_ff;
      has_result = 1'b0;
      result     = '0;

      if (phase_ff != PH_DONE) begin
         if (seen_ff < 3'd4) begin
            seen_in = seen_ff + 3'd1;
         end
         unique case (phase_ff)
            PH_START0: begin
               if (b != MK_PREFIX) begin
                  has_result = 1'b1;
                  result     = error_rsp(ST_NOT_JPEG);
               end else begin
                  phase_in = PH_START1;
               end
            end
            PH_START1: begin
               if (b != MK_SOI) begin
                  has_result = 1'b1;
                  result     = error_rsp(ST_NOT_JPEG);
               end else begin
                  phase_in = PH_SEEK;
               end
            end
            PH_SEEK: begin
               if (b == MK_PREFIX) begin
                  phase_in = PH_FILL;
               end
            end
            PH_FILL: begin
               if (b == MK_PREFIX) begin
                  phase_in = PH_FILL;
               end else if (b == MK_EOI || b == MK_SOS) begin
                  has_result = 1'b1;
                  result     = error_rsp(ST_NOT_FOUND);
               end else if (b >= MK_RST_FIRST && b <= MK_RST_LAST) begin
                  phase_in = PH_SEEK;
               end else begin
                  is_sof_in = sof_marker(b);
                  phase_in  = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               remain_in = {b, 8'h00};
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               remain_in = seg_len;
               if (seg_len < 16'd2) begin
                  has_result = 1'b1;
                  result     = error_rsp(ST_BAD_LENGTH);
               end else begin
                  remain_in = seg_len - 16'd2;
                  index_in  = 3'd0;
                  header_in = '0;
                  if (remain_in == 16'd0) begin
                     if (is_sof_ff) begin
                        has_result = 1'b1;
                        result     = finish_sof(3'd0, 48'd0);
                     end else begin
                        phase_in = PH_SEEK;
                     end
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (index_ff < SOF_HDR_BYTES) begin
                  header_in = {header_ff[39:0], b};
                  index_in  = index_ff + 3'd1;
               end
               remain_in = remain_ff - 16'd1;
               if (remain_in == 16'd0) begin
                  if (is_sof_ff) begin
                     has_result = 1'b1;
                     result     = finish_sof(index_in, header_in);
                  end else begin
                     phase_in = PH_SEEK;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (has_result) begin
            phase_in = PH_DONE;
         end
      end

      if (item.last_byte) begin
         if (phase_in != PH_DONE) begin
            has_result = 1'b1;
            if (phase_in == PH_START0 || phase_in == PH_START1 || seen_in < 3'd4) begin
               result = error_rsp(ST_NOT_JPEG);
            end else if (phase_in == PH_BODY) begin
               result = error_rsp(ST_BAD_LENGTH);
            end else begin
               result = error_rsp(ST_NOT_FOUND);
            end
         end
         // Return to the start of a new file.
         phase_in  = PH_START0;
         remain_in = '0;
         index_in  = '0;
         is_sof_in = 1'b0;
         seen_in   = '0;
         header_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START0;
         remain_ff <= '0;
         index_ff  <= '0;
         is_sof_ff <= 1'b0;
         seen_ff   <= '0;
         header_ff <= '0;
      end else if (ctl.consume) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         index_ff  <= index_in;
         is_sof_ff <= is_sof_in;
         seen_ff   <= seen_in;
         header_ff <= header_in;
      end
   end

endmodule

// ----- rtl/core/jfhs_out_reg.sv -----
// Result register of the JPEG frame header scanner.
// Holds one result item until the receiver takes it. Uses jfhs_pkg.
module jfhs_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  jfhs_pkg::rsp_type load_item,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jfhs_pkg::rsp_type rsp_item
);
   import jfhs_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// ----- rtl/core/jpeg_frame_header_scanner.sv -----
// JPEG frame header scanner: takes a JPEG file one byte per item and returns
// exactly one result item per file, the SOF precision, height, width and
// component count or an error status. One byte is taken every clock cycle;
// the only stall comes from a full result register. Each byte is held in the
// input register; its result, if any, then goes to the result register, and
// the byte stays in the input register while the result register is full.
// The byte flagged last always returns the scanner to the start of a new file.
// Uses jfhs_pkg, jfhs_in_reg, jfhs_parser and jfhs_out_reg.
module jpeg_frame_header_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jfhs_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jfhs_pkg::rsp_type rsp_item
);
   import jfhs_pkg::*;

   stage_ctl_type ctl;
   req_type       item;
   rsp_type       result;
   logic          has_result;
   logic          out_free;
   logic          consume;

   // A byte with no result moves on even while the result register is full.
   assign consume = ctl.item_valid && (!has_result || out_free);

   jfhs_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .consume   (consume),
      .ctl       (ctl),
      .item      (item)
   );

   jfhs_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .item       (item),
      .has_result (has_result),
      .result     (result)
   );

   jfhs_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (consume && has_result),
      .load_item (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_OK |->
         rsp_item.image_width == 16'd0 && rsp_item.image_height == 16'd0 &&
         rsp_item.component_count == 8'd0 && rsp_item.sample_precision == 8'd0)
      else $error("error result carries nonzero header fields");

   a_ok_fields_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_OK |->
         rsp_item.image_width != 16'd0 && rsp_item.image_height != 16'd0 &&
         (rsp_item.component_count == 8'd1 || rsp_item.component_count == 8'd3 ||
          rsp_item.component_count == 8'd4))
      else $error("ok result with invalid header fields");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ctl.item_valid && has_result && !out_free)
      else $error("input stalled without a blocked result");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      consume && has_result |-> out_free)
      else $error("result register overwritten while held");

endmodule

// ----- test/jpeg_frame_header_scanner_test.sv -----
// Self-checking testbench for jpeg_frame_header_scanner: streams JPEG-like files
// byte by byte and checks every result against a behavioral scanner model.
// Depends on jfhs_pkg and the scanner RTL only.
module jpeg_frame_header_scanner_test;
   import jfhs_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_BYTES = 470;

   typedef enum logic [3:0] {
      SCAN_START0, SCAN_START1, SCAN_SEEK, SCAN_FILL,
      SCAN_LEN_HI, SCAN_LEN_LO, SCAN_BODY, SCAN_DONE
   } scan_phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   // scanner model state
   scan_phase_type scan_phase;
   bit             scan_decided;
   logic [15:0]    seg_left;
   int             hdr_count;
   bit             seg_sof;
   int             bytes_seen;
   logic [47:0]    sof_hdr;

   rsp_type     expected_headers[$];
   req_type     byte_backlog[$];
   logic [7:0]  frame_buf[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int error_count = 0;
   int files_queued = 0;
   int bytes_sent = 0;
   int ok_results = 0;
   int err_results = 0;
   int quiet_cycles = 0;

   jpeg_frame_header_scanner u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit is_frame_marker(input logic [7:0] m);
      return m >= MK_SOF_FIRST && m <= MK_SOF_LAST && m != MK_DHT && m != MK_JPG
         && m != MK_DAC;
   endfunction

   // Append one byte to the file under construction.
   task automatic put_byte(input logic [7:0] v);
      frame_buf = {frame_buf, v};
   endtask

   task automatic clear_scan();
      scan_phase = SCAN_START0;
      scan_decided = 1'b0;
      seg_left = '0;
      hdr_count = 0;
      seg_sof = 1'b0;
      bytes_seen = 0;
      sof_hdr = '0;
   endtask

   task automatic post_header(input logic [2:0] st);
      rsp_type r;
      r = '0;
      r.status = st;
      if (st == ST_OK) begin
         r.sample_precision = sof_hdr[47:40];
         r.image_height = sof_hdr[39:24];
         r.image_width = sof_hdr[23:8];
         r.component_count = sof_hdr[7:0];
      end
      expected_headers = {expected_headers, r};
      scan_decided = 1'b1;
      scan_phase = SCAN_DONE;
   endtask

   task automatic finish_frame();
      if (hdr_count < int'(SOF_HDR_BYTES)) begin
         post_header(ST_SHORT_SOF);
      end else if (sof_hdr[23:8] == 16'd0 || sof_hdr[39:24] == 16'd0 ||
                   (sof_hdr[7:0] != 8'd1 && sof_hdr[7:0] != 8'd3 && sof_hdr[7:0] != 8'd4)) begin
         post_header(ST_BAD_VALUES);
      end else begin
         post_header(ST_OK);
      end
   endtask

   // Advance the scanner model by one accepted byte.
   task automatic scan_byte(input req_type it);
      logic [7:0] b;
      logic [2:0] st;
      b = it.data_byte;
      if (!scan_decided) begin
         if (bytes_seen < 4) bytes_seen++;
         case (scan_phase)
            SCAN_START0: begin
               if (b != MK_PREFIX) post_header(ST_NOT_JPEG);
               else scan_phase = SCAN_START1;
            end
            SCAN_START1: begin
               if (b != MK_SOI) post_header(ST_NOT_JPEG);
               else scan_phase = SCAN_SEEK;
            end
            SCAN_SEEK: begin
               if (b == MK_PREFIX) scan_phase = SCAN_FILL;
            end
            SCAN_FILL: begin
               if (b == MK_PREFIX) begin
                  // fill byte, stay
               end else if (b == MK_EOI || b == MK_SOS) begin
                  post_header(ST_NOT_FOUND);
               end else if (b >= MK_RST_FIRST && b <= MK_RST_LAST) begin
                  scan_phase = SCAN_SEEK;
               end else begin
                  seg_sof = is_frame_marker(b);
                  scan_phase = SCAN_LEN_HI;
               end
            end
            SCAN_LEN_HI: begin
               seg_left = {b, 8'h00};
               scan_phase = SCAN_LEN_LO;
            end
            SCAN_LEN_LO: begin
               seg_left = seg_left | {8'h00, b};
               if (seg_left < 16'd2) begin
                  post_header(ST_BAD_LENGTH);
               end else begin
                  seg_left = seg_left - 16'd2;
                  hdr_count = 0;
                  sof_hdr = '0;
                  if (seg_left == 16'd0) begin
                     if (seg_sof) finish_frame();
                     else scan_phase = SCAN_SEEK;
                  end else begin
                     scan_phase = SCAN_BODY;
                  end
               end
            end
            SCAN_BODY: begin
               if (hdr_count < int'(SOF_HDR_BYTES)) begin
                  sof_hdr = {sof_hdr[39:0], b};
                  hdr_count++;
               end
               seg_left = seg_left - 16'd1;
               if (seg_left == 16'd0) begin
                  if (seg_sof) finish_frame();
                  else scan_phase = SCAN_SEEK;
               end
            end
            default: begin
            end
         endcase
      end
      if (it.last_byte) begin
         if (!scan_decided) begin
            if (scan_phase == SCAN_START0 || scan_phase == SCAN_START1 || bytes_seen < 4)
               st = ST_NOT_JPEG;
            else if (scan_phase == SCAN_BODY)
               st = ST_BAD_LENGTH;
            else
               st = ST_NOT_FOUND;
            post_header(st);
         end
         clear_scan();
      end
   endtask

   task automatic put_len(input int len);
      put_byte(8'(len >> 8));
      put_byte(8'(len));
   endtask

   // Junk, restart markers and skippable segments between SOI and the target.
   task automatic add_segments();
      int         r;
      int         len;
      logic [7:0] m;
      repeat ($urandom_range(0, 3)) begin
         r = $urandom_range(0, 9);
         if (r < 2) begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 254)));
         end else if (r < 3) begin
            put_byte(MK_PREFIX);
            put_byte(MK_RST_FIRST + 8'($urandom_range(0, 7)));
         end else begin
            repeat ($urandom_range(0, 2)) put_byte(MK_PREFIX);
            m = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
               m = 8'h00;
            else if (m == MK_PREFIX || m == MK_EOI || m == MK_SOS || is_frame_marker(m) ||
                     (m >= MK_RST_FIRST && m <= MK_RST_LAST))
               m = 8'hE0 | (m & 8'h0F);
            put_byte(MK_PREFIX);
            put_byte(m);
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(2, 300) : $urandom_range(2, 8);
            put_len(len);
            repeat (len - 2) put_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic add_sof(input bit short_seg);
      logic [7:0] m;
      int         comps;
      int         prec;
      int         h;
      int         w;
      int         len;
      put_byte(MK_PREFIX);
      do m = MK_SOF_FIRST + 8'($urandom_range(0, 15));
      while (m == MK_DHT || m == MK_JPG || m == MK_DAC);
      put_byte(m);
      if (short_seg) begin
         len = $urandom_range(2, 7);
         put_len(len);
         repeat (len - 2) put_byte(8'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(0, 9))
         0:       comps = $urandom_range(0, 255);
         1, 2, 3: comps = 1;
         4, 5, 6: comps = 3;
         default: comps = 4;
      endcase
      prec = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 8;
      case ($urandom_range(0, 9))
         0:       h = 0;
         1:       h = 16'hFFFF;
         default: h = $urandom_range(1, 4000);
      endcase
      case ($urandom_range(0, 9))
         0:       w = 0;
         1:       w = 16'hFFFF;
         default: w = $urandom_range(1, 4000);
      endcase
      len = (comps <= 4) ? 8 + 3 * comps : 8 + $urandom_range(0, 6);
      put_len(len);
      put_byte(8'(prec));
      put_len(h);
      put_len(w);
      put_byte(8'(comps));
      repeat (len - 8) put_byte(8'($urandom_range(0, 255)));
   endtask

   // Build one file into frame_buf; most are well formed, the rest broken.
   task automatic build_frame(input int kind);
      int r;
      frame_buf = {};
      if (kind >= 95) begin
         if ($urandom_range(0, 1) == 0) begin
            put_byte(MK_PREFIX);
            put_byte(MK_SOI);
         end
         repeat ($urandom_range(1, 12))
            put_byte(($urandom_range(0, 3) == 0) ? MK_PREFIX : 8'($urandom_range(0, 255)));
         return;
      end
      put_byte(MK_PREFIX);
      put_byte(MK_SOI);
      add_segments();
      if (kind >= 90) begin
         put_byte(MK_PREFIX);
         put_byte(($urandom_range(0, 1) == 0) ? MK_EOI : MK_SOS);
      end else if (kind >= 85) begin
         put_byte(MK_PREFIX);
         put_byte(8'hE1);
         put_len($urandom_range(0, 1));
      end else begin
         add_sof(kind >= 80);
      end
      r = $urandom_range(0, 3);
      if (r == 1) begin
         put_byte(MK_PREFIX);
         put_byte(MK_EOI);
      end else if (r == 2) begin
         put_byte(MK_PREFIX);
         put_byte(MK_SOS);
         repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      end else if (r == 3) begin
         repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      end
      if (kind >= 65 && kind < 75) begin
         r = $urandom_range(1, frame_buf.size() - 1);
         while (frame_buf.size() > r) void'(frame_buf.pop_back());
      end else if (kind >= 75 && kind < 80) begin
         r = $urandom_range(0, 1);
         frame_buf[r] ^= 8'($urandom_range(1, 255));
      end
   endtask

   task automatic queue_frame();
      req_type t;
      foreach (frame_buf[i]) begin
         t.data_byte = frame_buf[i];
         t.last_byte = (i == frame_buf.size() - 1);
         byte_backlog = {byte_backlog, t};
      end
      files_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_backlog.size() != 0 || req_valid || expected_headers.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            scan_byte(req_item);
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_item <= byte_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (rsp_item.status == ST_OK) ok_results++;
            else err_results++;
            if (expected_headers.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: status %0d w %0d h %0d comps %0d prec %0d",
                           rsp_item.status, rsp_item.image_width, rsp_item.image_height,
                           rsp_item.component_count, rsp_item.sample_precision);
            end else begin
               want = expected_headers.pop_front();
               if (rsp_item.status !== want.status ||
                   rsp_item.image_width !== want.image_width ||
                   rsp_item.image_height !== want.image_height ||
                   rsp_item.component_count !== want.component_count ||
                   rsp_item.sample_precision !== want.sample_precision) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"mismatch: expected st %0d w %0d h %0d c %0d p %0d, ",
                               "got st %0d w %0d h %0d c %0d p %0d"},
                              want.status, want.image_width, want.image_height,
                              want.component_count, want.sample_precision,
                              rsp_item.status, rsp_item.image_width, rsp_item.image_height,
                              rsp_item.component_count, rsp_item.sample_precision);
               end
            end
         end
      end
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no item moved in %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, expected_headers.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int queued;
      clear_scan();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
            default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
         endcase
         if (ph == 0) begin
            // largest legal header values
            frame_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hC2, 8'h00, 8'h08,
                          8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h04};
            queue_frame();
            // bad first byte
            frame_buf = '{8'h00};
            queue_frame();
            // file shorter than four bytes
            frame_buf = '{8'hFF, 8'hD8, 8'hFF};
            queue_frame();
            // EOI before any frame header
            frame_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hD9};
            queue_frame();
            // stuffed zero taken as a marker, then a length below two
            frame_buf = '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h01};
            queue_frame();
         end
         queued = 0;
         while (queued < PHASE_BYTES) begin
            build_frame($urandom_range(0, 99));
            queued += frame_buf.size();
            queue_frame();
         end
         // hold off the next batch until every result is back
         wait_drained();
      end
      repeat (8) @(posedge clock);
      $display("ran %0d files (%0d bytes) through four idle/stall mixes", files_queued,
               bytes_sent);
      $display("results: %0d headers decoded, %0d error statuses, %0d failures",
               ok_results, err_results, error_count);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/jfhs_pkg.sv
rtl/core/jfhs_in_reg.sv
rtl/core/jfhs_parser.sv
rtl/core/jfhs_out_reg.sv
rtl/core/jpeg_frame_header_scanner.sv
test/jpeg_frame_header_scanner_test.sv
